>>> sv/bfd_pkg.sv
package bfd_pkg;

    // default glyph capacity of the width memory
    localparam int MAX_GLYPHS_DEF = 256;

    // stream geometry
    localparam int WORD_BITS      = 32;
    localparam int WIDTHS_PER_WORD = 4;

    // top level sequencer
    typedef enum logic [2:0] {
        ST_HEADER,
        ST_WIDTHS,
        ST_FETCH,
        ST_LOAD,
        ST_WORD,
        ST_RUN
    } bfd_state_t;

    // bit decoder inside one glyph row
    typedef enum logic [2:0] {
        SUB_FLAG,
        SUB_PIXEL,
        SUB_A1,
        SUB_A2,
        SUB_A3
    } bfd_sub_t;

    // one result item
    typedef struct packed {
        logic [7:0]  glyph_index;
        logic [8:0]  char_code;
        logic [7:0]  row;
        logic [7:0]  column;
        logic [7:0]  alpha;
        logic [7:0]  run_length;
        logic [23:0] pixel_offset;
        logic        last_of_glyph;
        logic        last_of_font;
    } bfd_run_t;

    // alpha for a three bit level: (255 * (n + 1)) >> 3
    function automatic logic [7:0] bfd_alpha(input logic [2:0] level);
        logic [7:0] a;
        case (level)
            3'd0:    a = 8'd31;
            3'd1:    a = 8'd63;
            3'd2:    a = 8'd95;
            3'd3:    a = 8'd127;
            3'd4:    a = 8'd159;
            3'd5:    a = 8'd191;
            3'd6:    a = 8'd223;
            default: a = 8'd255;
        endcase
        return a;
    endfunction

endpackage

>>> sv/bfd_word_if.sv
interface bfd_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] stream_word;

    modport source (output valid, output stream_word, input ready);
    modport sink (input valid, input stream_word, output ready);
endinterface

>>> sv/bfd_run_if.sv
interface bfd_run_if;
    logic        valid;
    logic        ready;
    logic [7:0]  glyph_index;
    logic [8:0]  char_code;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [23:0] pixel_offset;
    logic        last_of_glyph;
    logic        last_of_font;

    modport source (
        output valid, input ready,
        output glyph_index, output char_code, output row, output column,
        output alpha, output run_length, output pixel_offset,
        output last_of_glyph, output last_of_font
    );
    modport sink (
        input valid, output ready,
        input glyph_index, input char_code, input row, input column,
        input alpha, input run_length, input pixel_offset,
        input last_of_glyph, input last_of_font
    );
endinterface

>>> sv/bitmap_font_decompressor.sv
// Compressed bitmap font decoder. Words arrive on the words channel: a header
// (start character, glyph count, height), then the packed glyph widths, then an
// LSB-first bit stream; pixel runs leave on the runs channel, alpha only, each
// with its glyph, row, column and offset in the packed bitmap, and one end
// marker with the total bitmap size closes every font. Widths go to a
// synchronous memory of (MAX_GLYPHS+3)/4 words. A bit word is accepted, then
// decoded bit by bit, and the decoder then notices that it is used up. Each
// time it moves to the next glyph, the decoder steps the glyph index and then
// reads the width memory in the fetch and load states. The bit decoder stalls
// on a step that emits a result, and on the end marker, while a result waits
// in the output register and the runs channel is not ready.
module bitmap_font_decompressor #(
    parameter int MAX_GLYPHS = bfd_pkg::MAX_GLYPHS_DEF,
    localparam int WordDepth = (MAX_GLYPHS + bfd_pkg::WIDTHS_PER_WORD - 1)
                               / bfd_pkg::WIDTHS_PER_WORD,
    localparam int AddrW = (WordDepth > 1) ? $clog2(WordDepth) : 1
) (
    input  logic      clk,
    input  logic      rst_n,
    bfd_word_if.sink  words,
    bfd_run_if.source runs
);

    logic              ram_we;
    logic [AddrW-1:0]  ram_waddr;
    logic [31:0]       ram_wdata;
    logic [AddrW-1:0]  ram_raddr;
    logic [31:0]       ram_rdata;
    logic              slot_free;
    logic              push;
    bfd_pkg::bfd_run_t run;

    // glyph width memory, four widths per word
    bfd_ram #(
        .WIDTH (32),
        .DEPTH (WordDepth)
    ) u_width_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // stream parser and bit decoder
    bfd_decoder #(
        .MAX_GLYPHS (MAX_GLYPHS)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .words     (words),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .slot_free (slot_free),
        .push      (push),
        .run       (run)
    );

    // output register
    bfd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .run       (run),
        .slot_free (slot_free),
        .runs      (runs)
    );

    // a pending result is never overwritten
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> slot_free)
        else $error("result pushed into a full output register");

    // width memory is written only by an accepted word
    a_write_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (words.valid && words.ready))
        else $error("width memory written without an accepted word");

    // end marker has zero length and closes no glyph
    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (runs.valid && runs.last_of_font) |->
            ((runs.run_length == 8'd0) && !runs.last_of_glyph))
        else $error("malformed end of font marker");

    // zero length appears only on the end marker
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (runs.valid && (runs.run_length == 8'd0)) |-> runs.last_of_font)
        else $error("empty run that is not the end marker");

endmodule

>>> sv/bfd_ram.sv
module bfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/bfd_out.sv
module bfd_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bfd_pkg::bfd_run_t run,
    output logic              slot_free,
    bfd_run_if.source         runs
);

    logic              valid_reg;
    logic              valid_next;
    bfd_pkg::bfd_run_t data_reg;

    // slot opens when empty or being drained this cycle
    assign slot_free = !valid_reg || runs.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (runs.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= run;
        end
    end

    // drive the result channel
    assign runs.valid         = valid_reg;
    assign runs.glyph_index   = data_reg.glyph_index;
    assign runs.char_code     = data_reg.char_code;
    assign runs.row           = data_reg.row;
    assign runs.column        = data_reg.column;
    assign runs.alpha         = data_reg.alpha;
    assign runs.run_length    = data_reg.run_length;
    assign runs.pixel_offset  = data_reg.pixel_offset;
    assign runs.last_of_glyph = data_reg.last_of_glyph;
    assign runs.last_of_font  = data_reg.last_of_font;

endmodule

>>> sv/bfd_decoder.sv
module bfd_decoder #(
    parameter int MAX_GLYPHS = bfd_pkg::MAX_GLYPHS_DEF,
    localparam int WordDepth = (MAX_GLYPHS + bfd_pkg::WIDTHS_PER_WORD - 1)
                               / bfd_pkg::WIDTHS_PER_WORD,
    localparam int AddrW = (WordDepth > 1) ? $clog2(WordDepth) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    bfd_word_if.sink          words,
    output logic              ram_we,
    output logic [AddrW-1:0]  ram_waddr,
    output logic [31:0]       ram_wdata,
    output logic [AddrW-1:0]  ram_raddr,
    input  logic [31:0]       ram_rdata,
    input  logic              slot_free,
    output logic              push,
    output bfd_pkg::bfd_run_t run
);

    bfd_pkg::bfd_state_t state_reg, state_next;
    bfd_pkg::bfd_sub_t   sub_reg, sub_next;
    logic [7:0]  start_char_reg, start_char_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  height_reg, height_next;
    logic [6:0]  wcnt_reg, wcnt_next;
    logic [31:0] buf_reg, buf_next;
    logic [5:0]  bits_reg, bits_next;
    logic        live_reg, live_next;
    logic [8:0]  glyph_reg, glyph_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic [2:0]  level_reg, level_next;
    logic [23:0] row_base_reg, row_base_next;
    logic [7:0]  width_reg, width_next;

    logic        in_fire;
    logic [8:0]  eff_count;
    logic        done_c;
    logic        adv_c;
    logic        step_c;
    logic        bit_c;
    logic        emit_c;
    logic        go_c;
    logic        row_last;
    logic        col_last;
    logic [2:0]  level_full;
    logic [6:0]  width_words;
    logic [23:0] pix_offset;
    logic [23:0] row_base_inc;

    // shared decode of the current step
    assign in_fire     = words.valid && words.ready;
    assign eff_count   = ({1'b0, count_reg} < 9'(MAX_GLYPHS)) ? {1'b0, count_reg}
                                                               : 9'(MAX_GLYPHS);
    assign done_c      = (height_reg == 8'd0) || (glyph_reg >= eff_count);
    assign adv_c       = (row_reg == height_reg);
    assign step_c      = (state_reg == bfd_pkg::ST_RUN) && !done_c && !adv_c
                         && (bits_reg != 6'd0);
    assign bit_c       = buf_reg[0];
    assign row_last    = (9'(row_reg) + 9'd1) == {1'b0, height_reg};
    assign col_last    = (9'(col_reg) + 9'd1) == {1'b0, width_reg};
    assign level_full  = {level_reg[1:0], bit_c};
    assign width_words = 7'(({1'b0, count_reg} + 9'd3) >> 2);
    assign pix_offset  = row_base_reg + 24'(col_reg);
    assign row_base_inc = row_base_reg + 24'(width_reg);

    always_comb
    begin
        case (sub_reg)
            bfd_pkg::SUB_FLAG:  emit_c = !bit_c && (width_reg != 8'd0);
            bfd_pkg::SUB_PIXEL: emit_c = !bit_c;
            bfd_pkg::SUB_A3:    emit_c = 1'b1;
            default:            emit_c = 1'b0;
        endcase
    end

    assign go_c = step_c && (!emit_c || slot_free);

    // width memory ports
    assign ram_we    = (state_reg == bfd_pkg::ST_WIDTHS) && in_fire
                       && (wcnt_reg < 7'(WordDepth));
    assign ram_waddr = AddrW'(wcnt_reg);
    assign ram_wdata = words.stream_word;
    assign ram_raddr = AddrW'(glyph_reg >> 2);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfd_pkg::ST_HEADER:
            begin
                if (in_fire)
                begin
                    state_next = (words.stream_word[15:8] == 8'd0) ? bfd_pkg::ST_WORD
                                                                  : bfd_pkg::ST_WIDTHS;
                end
            end
            bfd_pkg::ST_WIDTHS:
            begin
                if (in_fire && ((wcnt_reg + 7'd1) >= width_words))
                begin
                    state_next = bfd_pkg::ST_FETCH;
                end
            end
            bfd_pkg::ST_FETCH:
            begin
                state_next = bfd_pkg::ST_LOAD;
            end
            bfd_pkg::ST_LOAD:
            begin
                state_next = live_reg ? bfd_pkg::ST_RUN : bfd_pkg::ST_WORD;
            end
            bfd_pkg::ST_WORD:
            begin
                if (in_fire)
                begin
                    state_next = bfd_pkg::ST_RUN;
                end
            end
            bfd_pkg::ST_RUN:
            begin
                if (done_c)
                begin
                    if (slot_free)
                    begin
                        state_next = bfd_pkg::ST_HEADER;
                    end
                end
                else if (adv_c)
                begin
                    state_next = bfd_pkg::ST_FETCH;
                end
                else if (bits_reg == 6'd0)
                begin
                    state_next = bfd_pkg::ST_WORD;
                end
            end
            default:
            begin
                state_next = bfd_pkg::ST_HEADER;
            end
        endcase
    end

    // handshake and result request
    always_comb
    begin
        words.ready = (state_reg == bfd_pkg::ST_HEADER) || (state_reg == bfd_pkg::ST_WIDTHS)
                      || (state_reg == bfd_pkg::ST_WORD);
        push = 1'b0;
        run.glyph_index   = glyph_reg[7:0];
        run.char_code     = {1'b0, start_char_reg} + {1'b0, glyph_reg[7:0]};
        run.row           = row_reg;
        run.column        = col_reg;
        run.alpha         = 8'd0;
        run.run_length    = 8'd1;
        run.pixel_offset  = pix_offset;
        run.last_of_glyph = row_last && col_last;
        run.last_of_font  = 1'b0;
        if ((state_reg == bfd_pkg::ST_RUN) && done_c)
        begin
            // end of font marker
            push = slot_free;
            run.glyph_index   = 8'd0;
            run.char_code     = {1'b0, start_char_reg};
            run.row           = 8'd0;
            run.column        = 8'd0;
            run.run_length    = 8'd0;
            run.pixel_offset  = row_base_reg;
            run.last_of_glyph = 1'b0;
            run.last_of_font  = 1'b1;
        end
        else if (go_c && emit_c)
        begin
            push = 1'b1;
            if (sub_reg == bfd_pkg::SUB_FLAG)
            begin
                // transparent full row
                run.column        = 8'd0;
                run.run_length    = width_reg;
                run.pixel_offset  = row_base_reg;
                run.last_of_glyph = row_last;
            end
            else if (sub_reg == bfd_pkg::SUB_A3)
            begin
                run.alpha = bfd_pkg::bfd_alpha(level_full);
            end
        end
    end

    // datapath next values
    always_comb
    begin
        sub_next        = sub_reg;
        start_char_next = start_char_reg;
        count_next      = count_reg;
        height_next     = height_reg;
        wcnt_next       = wcnt_reg;
        buf_next        = buf_reg;
        bits_next       = bits_reg;
        live_next       = live_reg;
        glyph_next      = glyph_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        level_next      = level_reg;
        row_base_next   = row_base_reg;
        width_next      = width_reg;
        case (state_reg)
            bfd_pkg::ST_HEADER:
            begin
                if (in_fire)
                begin
                    start_char_next = words.stream_word[7:0];
                    count_next      = words.stream_word[15:8];
                    height_next     = words.stream_word[23:16];
                    wcnt_next       = 7'd0;
                    live_next       = 1'b0;
                    glyph_next      = 9'd0;
                    row_next        = 8'd0;
                    col_next        = 8'd0;
                    sub_next        = bfd_pkg::SUB_FLAG;
                    level_next      = 3'd0;
                    row_base_next   = 24'd0;
                end
            end
            bfd_pkg::ST_WIDTHS:
            begin
                if (in_fire)
                begin
                    wcnt_next = wcnt_reg + 7'd1;
                end
            end
            bfd_pkg::ST_LOAD:
            begin
                // pick this glyph's byte out of the memory word
                width_next = ram_rdata[8 * glyph_reg[1:0] +: 8];
            end
            bfd_pkg::ST_WORD:
            begin
                if (in_fire)
                begin
                    buf_next  = words.stream_word;
                    bits_next = 6'(bfd_pkg::WORD_BITS);
                    live_next = 1'b1;
                end
            end
            bfd_pkg::ST_RUN:
            begin
                if (done_c)
                begin
                    if (slot_free)
                    begin
                        glyph_next    = 9'd0;
                        row_next      = 8'd0;
                        col_next      = 8'd0;
                        sub_next      = bfd_pkg::SUB_FLAG;
                        row_base_next = 24'd0;
                        bits_next     = 6'd0;
                        buf_next      = 32'd0;
                        live_next     = 1'b0;
                    end
                end
                else if (adv_c)
                begin
                    // glyph finished, its end offset is the next glyph base
                    glyph_next = glyph_reg + 9'd1;
                    row_next   = 8'd0;
                    col_next   = 8'd0;
                    sub_next   = bfd_pkg::SUB_FLAG;
                end
                else if (bits_reg == 6'd0)
                begin
                    live_next = 1'b0;
                end
                else if (go_c)
                begin
                    buf_next  = buf_reg >> 1;
                    bits_next = bits_reg - 6'd1;
                    case (sub_reg)
                        bfd_pkg::SUB_FLAG:
                        begin
                            if (!bit_c || (width_reg == 8'd0))
                            begin
                                row_next      = row_reg + 8'd1;
                                row_base_next = row_base_inc;
                            end
                            else
                            begin
                                col_next = 8'd0;
                                sub_next = bfd_pkg::SUB_PIXEL;
                            end
                        end
                        bfd_pkg::SUB_PIXEL:
                        begin
                            if (bit_c)
                            begin
                                level_next = 3'd0;
                                sub_next   = bfd_pkg::SUB_A1;
                            end
                            else if (col_last)
                            begin
                                col_next      = 8'd0;
                                row_next      = row_reg + 8'd1;
                                row_base_next = row_base_inc;
                                sub_next      = bfd_pkg::SUB_FLAG;
                            end
                            else
                            begin
                                col_next = col_reg + 8'd1;
                            end
                        end
                        bfd_pkg::SUB_A1:
                        begin
                            level_next = level_full;
                            sub_next   = bfd_pkg::SUB_A2;
                        end
                        bfd_pkg::SUB_A2:
                        begin
                            level_next = level_full;
                            sub_next   = bfd_pkg::SUB_A3;
                        end
                        bfd_pkg::SUB_A3:
                        begin
                            level_next = level_full;
                            if (col_last)
                            begin
                                col_next      = 8'd0;
                                row_next      = row_reg + 8'd1;
                                row_base_next = row_base_inc;
                                sub_next      = bfd_pkg::SUB_FLAG;
                            end
                            else
                            begin
                                col_next = col_reg + 8'd1;
                                sub_next = bfd_pkg::SUB_PIXEL;
                            end
                        end
                        default:
                        begin
                            sub_next = bfd_pkg::SUB_FLAG;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bfd_pkg::ST_HEADER;
            sub_reg      <= bfd_pkg::SUB_FLAG;
            count_reg    <= 8'd0;
            height_reg   <= 8'd0;
            wcnt_reg     <= 7'd0;
            bits_reg     <= 6'd0;
            live_reg     <= 1'b0;
            glyph_reg    <= 9'd0;
            row_reg      <= 8'd0;
            col_reg      <= 8'd0;
            row_base_reg <= 24'd0;
        end
        else
        begin
            state_reg    <= state_next;
            sub_reg      <= sub_next;
            count_reg    <= count_next;
            height_reg   <= height_next;
            wcnt_reg     <= wcnt_next;
            bits_reg     <= bits_next;
            live_reg     <= live_next;
            glyph_reg    <= glyph_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            row_base_reg <= row_base_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        start_char_reg <= start_char_next;
        buf_reg        <= buf_next;
        level_reg      <= level_next;
        width_reg      <= width_next;
    end

endmodule
